FILE: hdl/crfd_pkg.sv
// Shared constants for the cube rotate and face depth order unit:
// CORDIC arctangent table, start basis directions and sequencer step codes.
// No dependencies.
package crfd_pkg;

    localparam int COMPONENT_BITS_DEF = 18;
    localparam int CORDIC_STEPS       = 16;

    // CORDIC gain in Q4.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

    // arctangent of 2^-i, 2^32 per turn
    localparam logic [31:0] ATAN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    // start directions: entry face*3 + (up, right, out)
    localparam logic signed [1:0] START_DIR [18][3] = '{
        '{2'sd0, 2'sd0, -2'sd1}, '{2'sd1, 2'sd0, 2'sd0}, '{2'sd0, 2'sd1, 2'sd0},
        '{2'sd0, 2'sd0, 2'sd1},  '{2'sd1, 2'sd0, 2'sd0}, '{2'sd0, -2'sd1, 2'sd0},
        '{2'sd0, 2'sd0, -2'sd1}, '{2'sd0, 2'sd1, 2'sd0}, '{-2'sd1, 2'sd0, 2'sd0},
        '{2'sd0, -2'sd1, 2'sd0}, '{2'sd0, 2'sd0, 2'sd1}, '{2'sd1, 2'sd0, 2'sd0},
        '{2'sd0, 2'sd1, 2'sd0},  '{2'sd1, 2'sd0, 2'sd0}, '{2'sd0, 2'sd0, 2'sd1},
        '{2'sd1, 2'sd0, 2'sd0},  '{2'sd0, 2'sd1, 2'sd0}, '{2'sd0, 2'sd0, -2'sd1}
    };

    // multiply-accumulate steps
    localparam logic [4:0] ST_LEN0 = 5'd0;
    localparam logic [4:0] ST_LEN1 = 5'd1;
    localparam logic [4:0] ST_LEN2 = 5'd2;
    localparam logic [4:0] ST_DOT0 = 5'd3;
    localparam logic [4:0] ST_DOT1 = 5'd4;
    localparam logic [4:0] ST_DOT2 = 5'd5;
    localparam logic [4:0] ST_WGT  = 5'd6;
    localparam logic [4:0] ST_X0A  = 5'd7;
    localparam logic [4:0] ST_X0B  = 5'd8;
    localparam logic [4:0] ST_X1A  = 5'd9;
    localparam logic [4:0] ST_X1B  = 5'd10;
    localparam logic [4:0] ST_X2A  = 5'd11;
    localparam logic [4:0] ST_X2B  = 5'd12;
    localparam logic [4:0] ST_R0A  = 5'd13;
    localparam logic [4:0] ST_R0B  = 5'd14;
    localparam logic [4:0] ST_R0C  = 5'd15;
    localparam logic [4:0] ST_R1A  = 5'd16;
    localparam logic [4:0] ST_R1B  = 5'd17;
    localparam logic [4:0] ST_R1C  = 5'd18;
    localparam logic [4:0] ST_R2A  = 5'd19;
    localparam logic [4:0] ST_R2B  = 5'd20;
    localparam logic [4:0] ST_R2C  = 5'd21;

    typedef enum logic [3:0] {
        D_NONE, D_LEN, D_D, D_W, D_CR0, D_CR1, D_CR2, D_R0, D_R1, D_R2
    } t_dest;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_SQRT = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_CORD = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

endpackage

FILE: hdl/cube_rotate_and_face_depth_order_unit.sv
// Cube orientation unit: rotates an 18-vector face basis about a given axis
// and emits the six faces back to front. Depends on crfd_pkg.
//
// A command word runs the axis length, the bit-serial square root, three
// 17-step divisions, 16 CORDIC steps and the rotations (18 vectors, 19
// products each, each product passing the multiply state and then the
// accumulate state of the single multiply-accumulate unit) before it emits
// six words. A zero axis skips straight to emitting. The input is
// stalled while a command is in progress; the last result may still wait in
// the output register when the next command is taken.
module cube_rotate_and_face_depth_order_unit #(
    parameter int COMPONENT_BITS = crfd_pkg::COMPONENT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [15:0]  i_axis_x,
    input  logic signed [15:0]  i_axis_y,
    input  logic signed [15:0]  i_axis_z,
    input  logic [15:0]         i_angle,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_face_id,
    output logic signed [17:0]  o_depth_z,
    output logic                o_last,
    output logic                o_axis_error
);

    localparam int W    = COMPONENT_BITS;
    localparam int AW   = (W + 3 > 17) ? W + 3 : 17;
    localparam int BW   = 19;
    localparam int PW   = AW + BW;
    localparam int ACCW = PW + 2;
    localparam int ZW   = (W > 18) ? W : 18;

    localparam logic signed [W-1:0] P_ONE = (W > 17) ? W'(64'sd65536)
                                          : W'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [W-1:0] P_NEG = (W > 17) ? W'(-64'sd65536)
                                          : W'(-(64'sd1 <<< (W - 1)));
    localparam logic signed [ACCW-1:0] R_HI = ACCW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [ACCW-1:0] R_LO = ACCW'(-(64'sd1 <<< (W - 1)));
    localparam logic signed [ZW-1:0] Z_HI = ZW'(32'sd131071);
    localparam logic signed [ZW-1:0] Z_LO = ZW'(-32'sd131072);
    localparam logic signed [BW-1:0] ONE_B = BW'(32'sd65536);

    crfd_pkg::t_state r_state;

    logic signed [15:0]   r_ax, r_ay, r_az;
    logic [15:0]          r_angle;
    logic                 r_err;
    logic [4:0]           r_step;
    logic [4:0]           r_vec;
    logic [5:0]           r_cnt;
    logic signed [PW-1:0] r_prod;
    logic signed [ACCW-1:0] r_acc;
    logic signed [AW-1:0] r_d, r_w;
    logic signed [AW-1:0] r_cr [3];
    logic signed [17:0]   r_u [3];
    logic signed [17:0]   r_s, r_c;
    logic [31:0]          r_sqn;
    logic [34:0]          r_rem;
    logic [31:0]          r_root;
    logic [31:0]          r_drem;
    logic [16:0]          r_dq;
    logic [1:0]           r_dk;
    logic signed [33:0]   r_cx, r_cy;
    logic signed [32:0]   r_cz;
    logic                 r_neg;
    logic signed [W-1:0]  r_basis [18][3];
    logic [5:0]           r_used;

    // ---------------- multiply-accumulate step decode
    logic signed [W-1:0]  v0, v1, v2;
    logic signed [AW-1:0] op_a;
    logic signed [BW-1:0] op_b, omc;
    logic                 op_neg, op_first;
    crfd_pkg::t_dest      op_dest;

    assign v0  = r_basis[r_vec][0];
    assign v1  = r_basis[r_vec][1];
    assign v2  = r_basis[r_vec][2];
    assign omc = ONE_B - BW'(r_c);

    always_comb begin
        op_a     = '0;
        op_b     = '0;
        op_neg   = 1'b0;
        op_first = 1'b0;
        op_dest  = crfd_pkg::D_NONE;
        unique case (r_step)
            crfd_pkg::ST_LEN0: begin
                op_a = AW'(r_ax); op_b = BW'(r_ax); op_first = 1'b1;
            end
            crfd_pkg::ST_LEN1: begin
                op_a = AW'(r_ay); op_b = BW'(r_ay);
            end
            crfd_pkg::ST_LEN2: begin
                op_a = AW'(r_az); op_b = BW'(r_az); op_dest = crfd_pkg::D_LEN;
            end
            crfd_pkg::ST_DOT0: begin
                op_a = AW'(v0); op_b = BW'(r_u[0]); op_first = 1'b1;
            end
            crfd_pkg::ST_DOT1: begin
                op_a = AW'(v1); op_b = BW'(r_u[1]);
            end
            crfd_pkg::ST_DOT2: begin
                op_a = AW'(v2); op_b = BW'(r_u[2]); op_dest = crfd_pkg::D_D;
            end
            crfd_pkg::ST_WGT: begin
                op_a = r_d; op_b = omc; op_first = 1'b1; op_dest = crfd_pkg::D_W;
            end
            crfd_pkg::ST_X0A: begin
                op_a = AW'(v2); op_b = BW'(r_u[1]); op_first = 1'b1;
            end
            crfd_pkg::ST_X0B: begin
                op_a = AW'(v1); op_b = BW'(r_u[2]); op_neg = 1'b1;
                op_dest = crfd_pkg::D_CR0;
            end
            crfd_pkg::ST_X1A: begin
                op_a = AW'(v0); op_b = BW'(r_u[2]); op_first = 1'b1;
            end
            crfd_pkg::ST_X1B: begin
                op_a = AW'(v2); op_b = BW'(r_u[0]); op_neg = 1'b1;
                op_dest = crfd_pkg::D_CR1;
            end
            crfd_pkg::ST_X2A: begin
                op_a = AW'(v1); op_b = BW'(r_u[0]); op_first = 1'b1;
            end
            crfd_pkg::ST_X2B: begin
                op_a = AW'(v0); op_b = BW'(r_u[1]); op_neg = 1'b1;
                op_dest = crfd_pkg::D_CR2;
            end
            crfd_pkg::ST_R0A: begin
                op_a = AW'(v0); op_b = BW'(r_c); op_first = 1'b1;
            end
            crfd_pkg::ST_R0B: begin
                op_a = r_w; op_b = BW'(r_u[0]);
            end
            crfd_pkg::ST_R0C: begin
                op_a = r_cr[0]; op_b = BW'(r_s); op_dest = crfd_pkg::D_R0;
            end
            crfd_pkg::ST_R1A: begin
                op_a = AW'(v1); op_b = BW'(r_c); op_first = 1'b1;
            end
            crfd_pkg::ST_R1B: begin
                op_a = r_w; op_b = BW'(r_u[1]);
            end
            crfd_pkg::ST_R1C: begin
                op_a = r_cr[1]; op_b = BW'(r_s); op_dest = crfd_pkg::D_R1;
            end
            crfd_pkg::ST_R2A: begin
                op_a = AW'(v2); op_b = BW'(r_c); op_first = 1'b1;
            end
            crfd_pkg::ST_R2B: begin
                op_a = r_w; op_b = BW'(r_u[2]);
            end
            crfd_pkg::ST_R2C: begin
                op_a = r_cr[2]; op_b = BW'(r_s); op_dest = crfd_pkg::D_R2;
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    logic signed [PW-1:0]   mul_p;
    logic signed [ACCW-1:0] acc_sum, acc_rnd;
    logic signed [W-1:0]    acc_sat;

    assign mul_p   = PW'(op_a) * PW'(op_b);
    assign acc_sum = op_first ? ACCW'(r_prod)
                   : (op_neg ? r_acc - ACCW'(r_prod) : r_acc + ACCW'(r_prod));
    assign acc_rnd = (acc_sum + ACCW'(32'sd32768)) >>> 16;
    assign acc_sat = (acc_rnd > R_HI) ? W'(R_HI)
                   : ((acc_rnd < R_LO) ? W'(R_LO) : W'(acc_rnd));

    // ---------------- square root, two radicand bits a step
    logic [34:0] sq_sh, sq_try;
    logic        sq_ge;

    assign sq_sh  = {r_rem[32:0], r_sqn[31:30]};
    assign sq_try = {1'b0, r_root, 2'b01};
    assign sq_ge  = sq_sh >= sq_try;

    // ---------------- restoring divide, one quotient bit a step
    logic [32:0] dv_sh;
    logic        dv_ge;
    logic [16:0] dv_q;
    logic signed [17:0] dv_u;
    logic [15:0] mag_y;

    assign dv_sh = {r_drem, 1'b0};
    assign dv_ge = dv_sh >= {1'b0, r_root};
    assign dv_q  = {r_dq[15:0], dv_ge};
    assign dv_u  = r_ax[15] ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});
    assign mag_y = r_ay[15] ? 16'(~r_ay + 16'sd1) : 16'(r_ay);

    logic [15:0] mag_x_in;
    assign mag_x_in = r_ax[15] ? 16'(~r_ax + 16'sd1) : 16'(r_ax);

    // ---------------- CORDIC
    logic signed [16:0] fa, fa_fold;
    logic               fa_neg;
    logic signed [33:0] cd_dx, cd_dy, n_cx, n_cy, cd_cos, cd_sin;
    logic signed [32:0] n_cz;
    logic signed [19:0] cs20, sn20;
    logic signed [17:0] cs_cl, sn_cl;

    assign fa = 17'($signed(r_angle));

    always_comb begin
        fa_fold = fa;
        fa_neg  = 1'b0;
        if (fa > 17'sd16384) begin
            fa_fold = fa - 17'sd32768;
            fa_neg  = 1'b1;
        end else if (fa < -17'sd16384) begin
            fa_fold = fa + 17'sd32768;
            fa_neg  = 1'b1;
        end
    end

    assign cd_dx = r_cy >>> r_cnt[3:0];
    assign cd_dy = r_cx >>> r_cnt[3:0];

    always_comb begin
        if (!r_cz[32]) begin
            n_cx = r_cx - cd_dx;
            n_cy = r_cy + cd_dy;
            n_cz = r_cz - 33'(crfd_pkg::ATAN[r_cnt[3:0]]);
        end else begin
            n_cx = r_cx + cd_dx;
            n_cy = r_cy - cd_dy;
            n_cz = r_cz + 33'(crfd_pkg::ATAN[r_cnt[3:0]]);
        end
    end

    assign cd_cos = (n_cx + 34'sd8192) >>> 14;
    assign cd_sin = (n_cy + 34'sd8192) >>> 14;
    assign cs20   = r_neg ? -20'(cd_cos) : 20'(cd_cos);
    assign sn20   = r_neg ? -20'(cd_sin) : 20'(cd_sin);
    assign cs_cl  = (cs20 > 20'sd65536) ? 18'sd65536
                  : ((cs20 < -20'sd65536) ? -18'sd65536 : 18'(cs20));
    assign sn_cl  = (sn20 > 20'sd65536) ? 18'sd65536
                  : ((sn20 < -20'sd65536) ? -18'sd65536 : 18'(sn20));

    // ---------------- back-to-front pick: smallest z, lowest face on ties
    logic               em_found;
    logic [2:0]         em_idx;
    logic signed [W-1:0] em_z;
    logic signed [ZW-1:0] em_zx;
    logic signed [17:0] em_depth;
    logic               em_load;

    always_comb begin
        em_found = 1'b0;
        em_idx   = '0;
        em_z     = '0;
        for (int i = 0; i < 6; i++) begin
            if (!r_used[i] && (!em_found || r_basis[i*3+2][2] < em_z)) begin
                em_found = 1'b1;
                em_idx   = 3'(i);
                em_z     = r_basis[i*3+2][2];
            end
        end
    end

    assign em_zx    = ZW'(em_z);
    assign em_depth = (em_zx > Z_HI) ? 18'(Z_HI)
                    : ((em_zx < Z_LO) ? 18'(Z_LO) : 18'(em_zx));
    assign em_load  = (r_state == crfd_pkg::S_EMIT) && (!o_valid || !i_stall);

    assign o_stall = (r_state != crfd_pkg::S_IDLE);

    // ---------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crfd_pkg::S_IDLE;
            r_step  <= '0;
            r_vec   <= '0;
            r_cnt   <= '0;
            r_used  <= '0;
            r_err   <= 1'b0;
            o_valid <= 1'b0;
            for (int e = 0; e < 18; e++) begin
                for (int k = 0; k < 3; k++) begin
                    r_basis[e][k] <= (crfd_pkg::START_DIR[e][k] == 2'sd1) ? P_ONE
                                   : ((crfd_pkg::START_DIR[e][k] == -2'sd1) ? P_NEG
                                   : '0);
                end
            end
        end else begin
            // load the next word while emitting, drop the word once taken
            if (em_load) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end

            unique case (r_state)
                crfd_pkg::S_IDLE: begin
                    if (i_valid) begin
                        r_ax    <= i_axis_x;
                        r_ay    <= i_axis_y;
                        r_az    <= i_axis_z;
                        r_angle <= i_angle;
                        r_err   <= 1'b0;
                        r_step  <= crfd_pkg::ST_LEN0;
                        r_state <= crfd_pkg::S_MUL;
                    end
                end

                crfd_pkg::S_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= crfd_pkg::S_ACC;
                end

                crfd_pkg::S_ACC: begin
                    r_acc <= acc_sum;
                    case (op_dest)
                        crfd_pkg::D_D:   r_d     <= AW'(acc_rnd);
                        crfd_pkg::D_W:   r_w     <= AW'(acc_rnd);
                        crfd_pkg::D_CR0: r_cr[0] <= AW'(acc_rnd);
                        crfd_pkg::D_CR1: r_cr[1] <= AW'(acc_rnd);
                        crfd_pkg::D_CR2: r_cr[2] <= AW'(acc_rnd);
                        crfd_pkg::D_R0:  r_basis[r_vec][0] <= acc_sat;
                        crfd_pkg::D_R1:  r_basis[r_vec][1] <= acc_sat;
                        crfd_pkg::D_R2:  r_basis[r_vec][2] <= acc_sat;
                        default: begin
                        end
                    endcase
                    if (op_dest == crfd_pkg::D_LEN) begin
                        r_cnt  <= '0;
                        r_step <= r_step + 5'd1;
                        if (acc_sum == '0) begin
                            r_err   <= 1'b1;
                            r_used  <= '0;
                            r_state <= crfd_pkg::S_EMIT;
                        end else begin
                            r_sqn   <= acc_sum[31:0];
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_state <= crfd_pkg::S_SQRT;
                        end
                    end else if (op_dest == crfd_pkg::D_R2) begin
                        r_step <= crfd_pkg::ST_DOT0;
                        if (r_vec == 5'd17) begin
                            r_used  <= '0;
                            r_cnt   <= '0;
                            r_state <= crfd_pkg::S_EMIT;
                        end else begin
                            r_vec   <= r_vec + 5'd1;
                            r_state <= crfd_pkg::S_MUL;
                        end
                    end else begin
                        r_step  <= r_step + 5'd1;
                        r_state <= crfd_pkg::S_MUL;
                    end
                end

                crfd_pkg::S_SQRT: begin
                    r_rem  <= sq_ge ? sq_sh - sq_try : sq_sh;
                    r_root <= {r_root[30:0], sq_ge};
                    r_sqn  <= {r_sqn[29:0], 2'b00};
                    if (r_cnt == 6'd31) begin
                        r_cnt   <= '0;
                        r_dk    <= '0;
                        r_drem  <= {1'b0, mag_x_in, 15'd0};
                        r_state <= crfd_pkg::S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end

                crfd_pkg::S_DIV: begin
                    r_dq <= dv_q;
                    if (r_cnt == 6'd16) begin
                        // rotate the axis words so the next component sits in x
                        r_u[r_dk] <= dv_u;
                        r_ax      <= r_ay;
                        r_ay      <= r_az;
                        r_az      <= r_ax;
                        r_drem    <= {1'b0, mag_y, 15'd0};
                        r_cnt     <= '0;
                        r_dk      <= r_dk + 2'd1;
                        if (r_dk == 2'd2) begin
                            r_cx    <= crfd_pkg::CORDIC_GAIN;
                            r_cy    <= '0;
                            r_cz    <= 33'(fa_fold) <<< 16;
                            r_neg   <= fa_neg;
                            r_state <= crfd_pkg::S_CORD;
                        end
                    end else begin
                        r_drem <= dv_ge ? 32'(dv_sh - {1'b0, r_root}) : dv_sh[31:0];
                        r_cnt  <= r_cnt + 6'd1;
                    end
                end

                crfd_pkg::S_CORD: begin
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_cz <= n_cz;
                    if (r_cnt == 6'(crfd_pkg::CORDIC_STEPS - 1)) begin
                        r_c     <= cs_cl;
                        r_s     <= sn_cl;
                        r_cnt   <= '0;
                        r_vec   <= '0;
                        r_step  <= crfd_pkg::ST_DOT0;
                        r_state <= crfd_pkg::S_MUL;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end

                crfd_pkg::S_EMIT: begin
                    if (em_load) begin
                        o_face_id    <= em_idx;
                        o_depth_z    <= em_depth;
                        o_last       <= (r_cnt == 6'd5);
                        o_axis_error <= r_err;
                        r_used[em_idx] <= 1'b1;
                        if (r_cnt == 6'd5) begin
                            r_cnt   <= '0;
                            r_state <= crfd_pkg::S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 6'd1;
                        end
                    end
                end

                default: begin
                    r_state <= crfd_pkg::S_IDLE;
                end
            endcase
        end
    end

endmodule
